// ===== hdl/pdmse_pkg.sv =====
`timescale 1ns / 1ps

package pdmse_pkg;

   localparam int PCM_W = 16;
   localparam int WORD_W = 32;
   localparam int RES_W = 17;   // sample - mid-scale, signed
   localparam int ADJ_W = 18;   // res +/- mid-scale, signed
   localparam int INTEG_W = 32;
   localparam int LOW_W = 17;   // bits of the second integrator kept by the feedback mask
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PCM_W-1:0] MID_SCALE = 16'd32767;
   localparam logic [INTEG_W-1:0] MID_SCALE_W = 32'd32767;

   typedef logic signed [RES_W-1:0] res_type;
   typedef logic signed [ADJ_W-1:0] adj_type;

   // One classified request on its way from front to back
   typedef struct packed {
      logic valid;
      res_type res;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic busy;
      logic fin;
   } back_stat_type;

endpackage

// ===== hdl/pdmse_if.sv =====
`timescale 1ns / 1ps

interface pdmse_req_if import pdmse_pkg::*;;
   logic valid;
   logic ready;
   logic [PCM_W-1:0] pcm_sample;
   logic sample_present;

   modport source (output valid, output pcm_sample, output sample_present, input ready);
   modport sink (input valid, input pcm_sample, input sample_present, output ready);
endinterface

interface pdmse_rsp_if import pdmse_pkg::*;;
   logic valid;
   logic ready;
   logic [WORD_W-1:0] pdm_word;

   modport source (output valid, output pdm_word, input ready);
   modport sink (input valid, input pdm_word, output ready);
endinterface

// ===== hdl/pdmse_front.sv =====
`timescale 1ns / 1ps

module pdmse_front import pdmse_pkg::*; (
   pdmse_req_if.sink req_port,
   input queue_stat_type q_stat,
   output queue_entry_type push
);

   logic [RES_W-1:0] centred;

   // centre the sample on mid-scale; silence is encoded by sample_present low
   assign centred = {1'b0, req_port.pcm_sample} - {1'b0, MID_SCALE};

   always_comb begin
      push.valid = req_port.valid;
      push.res = req_port.sample_present ? res_type'(centred) : '0;
   end

   assign req_port.ready = !q_stat.full;

endmodule

// ===== hdl/pdmse_queue.sv =====
`timescale 1ns / 1ps

module pdmse_queue import pdmse_pkg::*; (
   input logic clock,
   input logic reset,
   input queue_entry_type push,
   input logic pop,
   output queue_entry_type head,
   output queue_stat_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   res_type store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign q_stat.full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push = push.valid && !q_stat.full;
   assign do_pop = pop && !q_stat.empty;

   always_comb begin
      head.valid = !q_stat.empty;
      head.res = store_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.res;
      end
   end

endmodule

// ===== hdl/pdmse_back.sv =====
`timescale 1ns / 1ps

module pdmse_back import pdmse_pkg::*; #(
   parameter int BITS_PER_SAMPLE = 32
) (
   input logic clock,
   input logic reset,
   input queue_entry_type head,
   output logic pop,
   pdmse_rsp_if.source rsp_port,
   output back_stat_type b_stat
);

   localparam int CNT_W = $clog2(BITS_PER_SAMPLE);
   localparam int ALIGN = (BITS_PER_SAMPLE < WORD_W) ? (WORD_W - BITS_PER_SAMPLE) : 0;

   logic busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   adj_type adj_pos_ff, adj_pos_in;   // res - mid-scale
   adj_type adj_neg_ff, adj_neg_in;   // res + mid-scale
   logic [INTEG_W-1:0] first_ff, first_in;
   logic [INTEG_W-1:0] second_ff, second_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_word_ff, out_word_in;

   logic last;
   logic fire;
   logic fin;
   logic load;
   logic bit_one;
   logic [INTEG_W-1:0] first_step;
   logic [INTEG_W-1:0] fb_term;
   logic [WORD_W-1:0] shift_step;

   assign last = (cnt_ff == CNT_W'(BITS_PER_SAMPLE - 1));
   // hold on the final bit while the previous word is still unclaimed
   assign fire = busy_ff && !(last && out_valid_ff && !rsp_port.ready);
   assign fin = fire && last;
   assign load = !busy_ff || fin;
   assign pop = load && head.valid;

   assign bit_one = !second_ff[INTEG_W-1];

   always_comb begin
      if (bit_one) begin
         first_step = first_ff + INTEG_W'(adj_pos_ff);
         fb_term = {{(INTEG_W - LOW_W){1'b0}}, second_ff[LOW_W-1:0]} - MID_SCALE_W;
      end else begin
         first_step = first_ff + INTEG_W'(adj_neg_ff);
         fb_term = {{(INTEG_W - LOW_W){1'b1}}, second_ff[LOW_W-1:0]} + MID_SCALE_W;
      end
      shift_step = {shift_ff[WORD_W-2:0], bit_one};
   end

   always_comb begin
      busy_in = load ? head.valid : busy_ff;
      cnt_in = cnt_ff;
      adj_pos_in = adj_pos_ff;
      adj_neg_in = adj_neg_ff;
      first_in = first_ff;
      second_in = second_ff;
      shift_in = shift_ff;
      out_word_in = out_word_ff;
      out_valid_in = rsp_port.ready ? 1'b0 : out_valid_ff;

      if (fire) begin
         first_in = first_step;
         second_in = first_step + fb_term;
         shift_in = shift_step;
         cnt_in = fin ? '0 : cnt_ff + 1'b1;
      end
      if (fin) begin
         out_valid_in = 1'b1;
         out_word_in = shift_step << ALIGN;
      end
      if (pop) begin
         adj_pos_in = ADJ_W'(head.res) - adj_type'(MID_SCALE_W);
         adj_neg_in = ADJ_W'(head.res) + adj_type'(MID_SCALE_W);
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         first_ff <= '0;
         second_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         first_ff <= first_in;
         second_ff <= second_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      adj_pos_ff <= adj_pos_in;
      adj_neg_ff <= adj_neg_in;
      shift_ff <= shift_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.pdm_word = out_word_ff;

   always_comb begin
      b_stat.busy = busy_ff;
      b_stat.fin = fin;
   end

endmodule

// ===== hdl/pdm_sigma_delta_encoder.sv =====
`timescale 1ns / 1ps

// Second-order sigma-delta PDM encoder.
// req_port (sink): one PCM request per handshake, pcm_sample (16-bit unsigned,
//   mid-scale 32767) and sample_present; sample_present low encodes silence.
// rsp_port (source): one pdm_word per request, first modulator bit in bit 31.
// Front end classifies the request (centres the sample) and pushes it into a
// two-deep queue; the back end runs one modulator step per clock unless stalled.
// Each request yields BITS_PER_SAMPLE modulator bits (32 by default); the back
//   end takes one request at a time through the single shared integrator step.
// The next request starts the cycle after the previous word is finished, so
//   words come out back to back while the queue is fed.
// Stall: a finished word sits in the output register; the back end holds on
//   the last bit of the following word until it is taken, then the queue
//   fills and req ready drops.
// Reset (synchronous, active high): both integrators to zero, queue and
//   output register emptied.
module pdm_sigma_delta_encoder import pdmse_pkg::*; #(
   parameter int BITS_PER_SAMPLE = 32
) (
   input logic clock,
   input logic reset,
   pdmse_req_if.sink req_port,
   pdmse_rsp_if.source rsp_port
);

   queue_entry_type push;
   queue_entry_type head;
   queue_stat_type q_stat;
   back_stat_type b_stat;
   logic pop;

   pdmse_front u_front (
      .req_port (req_port),
      .q_stat   (q_stat),
      .push     (push)
   );

   pdmse_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   pdmse_back #(
      .BITS_PER_SAMPLE (BITS_PER_SAMPLE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_port (rsp_port),
      .b_stat   (b_stat)
   );

`ifndef SYNTHESIS
   // queued request must be picked up by an idle back end
   a_idle_picks_up: assert property (@(posedge clock) disable iff (reset)
      (!q_stat.empty && !b_stat.busy) |=> b_stat.busy)
      else $error("back end stayed idle with a queued request");

   // a new word only appears after the last modulator step
   a_word_after_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_port.valid) |-> $past(b_stat.fin))
      else $error("response raised without a finished word");

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");
`endif

endmodule
